@@ src/dmm_pkg.sv @@
// shared constants, types and helpers for the dense matrix multiply block
`default_nettype none

package dmm_pkg;

    // sizes of the local stores
    localparam int MAX_ROWS  = 8;
    localparam int MAX_COLS  = 8;
    localparam int MAX_INNER = 8;

    // field widths
    localparam int VAL_W      = 16;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int SUM_W      = 35;
    localparam int IDX_W      = 3;
    localparam int ACT_W      = 2;
    localparam int CFG_W      = 4;
    localparam int CFG_ADDR_W = 2;

    // inner index and inner count widths
    localparam int IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int KW = $clog2(MAX_INNER + 1);

    // store address widths
    localparam int AW_A = (MAX_ROWS * MAX_INNER > 1) ? $clog2(MAX_ROWS * MAX_INNER) : 1;
    localparam int AW_B = (MAX_INNER * MAX_COLS > 1) ? $clog2(MAX_INNER * MAX_COLS) : 1;
    localparam int DEPTH_A = MAX_ROWS * MAX_INNER;
    localparam int DEPTH_B = MAX_INNER * MAX_COLS;

    // action codes
    localparam logic [ACT_W-1:0] ACT_WR_A = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WR_B = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RUN  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLS_B    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INNER_LEN = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic              rd_en;
        logic [IDX_W-1:0]  idx_row;
        logic [IDX_W-1:0]  idx_col;
        logic [IW-1:0]     idx_inner;
        logic              acc_clear;
        logic              emit;
        logic              emit_last;
    } dmm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dmm_status_t;

    function automatic logic [AW_A-1:0] addr_a(input int r, input int c);
        return AW_A'(r * MAX_INNER + c);
    endfunction

    function automatic logic [AW_B-1:0] addr_b(input int r, input int c);
        return AW_B'(r * MAX_COLS + c);
    endfunction

endpackage

`default_nettype wire

@@ src/dense_matrix_multiply_top.sv @@
// top level of the dense matrix multiply block
// timing: a load beat of A or B is written to its store when accepted; in a run each result
//   passes the store read registers, product register and accumulator to the output register
// throughput: loads one beat per cycle while idle; a run works out one result at a time,
//   set by the single shared multiply-accumulate fed by one read port on each store
// a run of m x n results keeps in_ready low until its last result enters the output register
// reset: sizes go to 8, sequencer idle, output register empty; stores are not cleared
`default_nettype none

module dense_matrix_multiply_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [dmm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [dmm_pkg::CFG_W-1:0]          cfg_wdata,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [dmm_pkg::ACT_W-1:0]          action,
    input  wire logic [dmm_pkg::IDX_W-1:0]          row,
    input  wire logic [dmm_pkg::IDX_W-1:0]          col,
    input  wire logic signed [dmm_pkg::VAL_W-1:0]   value,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [dmm_pkg::IDX_W-1:0]               out_row,
    output logic [dmm_pkg::IDX_W-1:0]               out_col,
    output logic signed [dmm_pkg::SUM_W-1:0]        product_sum,
    output logic                                    last
);

    // command and status between sequencer and datapath
    dmm_pkg::dmm_cmd_t    cmd;
    dmm_pkg::dmm_status_t status;

    // sequencer: holds sizes, walks row, column and inner index,
    // takes load beats and run beats only while idle
    dmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: two element stores, registered read, multiply, accumulate,
    // then an output register that frees the sequencer from the consumer
    dmm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .row         (row),
        .col         (col),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .product_sum (product_sum),
        .last        (last)
    );

endmodule

`default_nettype wire

@@ src/dmm_ctrl.sv @@
// controller: configuration registers, run sequencer state machine and index counters
`default_nettype none

module dmm_ctrl (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [dmm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [dmm_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [dmm_pkg::ACT_W-1:0]          action,
    input  wire dmm_pkg::dmm_status_t               status,
    output dmm_pkg::dmm_cmd_t                       cmd
);

    logic [dmm_pkg::CFG_W-1:0] rows_a_reg;
    logic [dmm_pkg::CFG_W-1:0] cols_b_reg;
    logic [dmm_pkg::CFG_W-1:0] inner_len_reg;

    dmm_pkg::state_t state_reg, state_next;

    logic [dmm_pkg::IDX_W-1:0] i_reg, i_next;
    logic [dmm_pkg::IDX_W-1:0] j_reg, j_next;
    logic [dmm_pkg::KW-1:0]    l_reg, l_next;

    logic [dmm_pkg::CFG_W-1:0] m_clamp;
    logic [dmm_pkg::CFG_W-1:0] n_clamp;
    logic [dmm_pkg::KW-1:0]    k_clamp;

    logic run_start;
    logic last_inner;
    logic last_col;
    logic last_elem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= dmm_pkg::CFG_RESET;
            cols_b_reg    <= dmm_pkg::CFG_RESET;
            inner_len_reg <= dmm_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                dmm_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                dmm_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_wdata;
                dmm_pkg::CFG_INNER_LEN: inner_len_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // saturate sizes to the store dimensions
    assign m_clamp = (int'(rows_a_reg) > dmm_pkg::MAX_ROWS) ?
                     dmm_pkg::CFG_W'(dmm_pkg::MAX_ROWS) : rows_a_reg;
    assign n_clamp = (int'(cols_b_reg) > dmm_pkg::MAX_COLS) ?
                     dmm_pkg::CFG_W'(dmm_pkg::MAX_COLS) : cols_b_reg;
    assign k_clamp = (int'(inner_len_reg) > dmm_pkg::MAX_INNER) ?
                     dmm_pkg::KW'(dmm_pkg::MAX_INNER) : dmm_pkg::KW'(inner_len_reg);

    assign run_start  = (state_reg == dmm_pkg::ST_IDLE) && in_valid &&
                        (action == dmm_pkg::ACT_RUN);
    assign last_inner = (l_reg + dmm_pkg::KW'(1)) == k_clamp;
    assign last_col   = (dmm_pkg::CFG_W'(j_reg) + dmm_pkg::CFG_W'(1)) == n_clamp;
    assign last_elem  = last_col &&
                        ((dmm_pkg::CFG_W'(i_reg) + dmm_pkg::CFG_W'(1)) == m_clamp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmm_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            l_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            l_reg     <= l_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dmm_pkg::ST_IDLE:
            begin
                if (run_start && m_clamp != '0 && n_clamp != '0)
                begin
                    state_next = (k_clamp == '0) ? dmm_pkg::ST_DRAIN1 : dmm_pkg::ST_ISSUE;
                end
            end
            dmm_pkg::ST_ISSUE:
            begin
                if (last_inner)
                begin
                    state_next = dmm_pkg::ST_DRAIN1;
                end
            end
            dmm_pkg::ST_DRAIN1: state_next = dmm_pkg::ST_DRAIN2;
            dmm_pkg::ST_DRAIN2: state_next = dmm_pkg::ST_EMIT;
            dmm_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    if (last_elem)
                        state_next = dmm_pkg::ST_IDLE;
                    else if (k_clamp == '0)
                        state_next = dmm_pkg::ST_DRAIN1;
                    else
                        state_next = dmm_pkg::ST_ISSUE;
                end
            end
            default: state_next = dmm_pkg::ST_IDLE;
        endcase
    end

    // index counters
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        l_next = l_reg;
        case (state_reg)
            dmm_pkg::ST_IDLE:
            begin
                if (run_start)
                begin
                    i_next = '0;
                    j_next = '0;
                    l_next = '0;
                end
            end
            dmm_pkg::ST_ISSUE:
            begin
                l_next = l_reg + dmm_pkg::KW'(1);
            end
            dmm_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    l_next = '0;
                    if (last_col)
                    begin
                        j_next = '0;
                        i_next = i_reg + dmm_pkg::IDX_W'(1);
                    end
                    else
                    begin
                        j_next = j_reg + dmm_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = (state_reg == dmm_pkg::ST_IDLE);
        cmd.wr_a      = (state_reg == dmm_pkg::ST_IDLE) && in_valid &&
                        (action == dmm_pkg::ACT_WR_A);
        cmd.wr_b      = (state_reg == dmm_pkg::ST_IDLE) && in_valid &&
                        (action == dmm_pkg::ACT_WR_B);
        cmd.rd_en     = (state_reg == dmm_pkg::ST_ISSUE);
        cmd.idx_row   = i_reg;
        cmd.idx_col   = j_reg;
        cmd.idx_inner = l_reg[dmm_pkg::IW-1:0];
        cmd.emit      = (state_reg == dmm_pkg::ST_EMIT) && status.out_free;
        cmd.emit_last = last_elem;
        cmd.acc_clear = run_start || cmd.emit;
    end

endmodule

`default_nettype wire

@@ src/dmm_datapath.sv @@
// datapath: element stores, multiply-accumulate pipeline and output register
`default_nettype none

module dmm_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire dmm_pkg::dmm_cmd_t                  cmd,
    output dmm_pkg::dmm_status_t                    status,
    input  wire logic [dmm_pkg::IDX_W-1:0]          row,
    input  wire logic [dmm_pkg::IDX_W-1:0]          col,
    input  wire logic signed [dmm_pkg::VAL_W-1:0]   value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [dmm_pkg::IDX_W-1:0]               out_row,
    output logic [dmm_pkg::IDX_W-1:0]               out_col,
    output logic signed [dmm_pkg::SUM_W-1:0]        product_sum,
    output logic                                    last
);

    logic signed [dmm_pkg::VAL_W-1:0] store_a_reg [dmm_pkg::DEPTH_A];
    logic signed [dmm_pkg::VAL_W-1:0] store_b_reg [dmm_pkg::DEPTH_B];

    logic signed [dmm_pkg::VAL_W-1:0]  rd_a_reg;
    logic signed [dmm_pkg::VAL_W-1:0]  rd_b_reg;
    logic signed [dmm_pkg::PROD_W-1:0] prod_reg;
    logic signed [dmm_pkg::SUM_W-1:0]  acc_reg;

    logic rd_valid_reg;
    logic prod_valid_reg;
    logic out_valid_reg;

    logic [dmm_pkg::IDX_W-1:0]        out_row_reg;
    logic [dmm_pkg::IDX_W-1:0]        out_col_reg;
    logic signed [dmm_pkg::SUM_W-1:0] product_sum_reg;
    logic                             last_reg;

    logic                    wr_a_ok;
    logic                    wr_b_ok;
    logic [dmm_pkg::AW_A-1:0] wr_addr_a;
    logic [dmm_pkg::AW_B-1:0] wr_addr_b;
    logic [dmm_pkg::AW_A-1:0] rd_addr_a;
    logic [dmm_pkg::AW_B-1:0] rd_addr_b;

    // out of range writes are dropped
    assign wr_a_ok = cmd.wr_a && (int'(row) < dmm_pkg::MAX_ROWS) &&
                     (int'(col) < dmm_pkg::MAX_INNER);
    assign wr_b_ok = cmd.wr_b && (int'(row) < dmm_pkg::MAX_INNER) &&
                     (int'(col) < dmm_pkg::MAX_COLS);

    assign wr_addr_a = dmm_pkg::addr_a(int'(row), int'(col));
    assign wr_addr_b = dmm_pkg::addr_b(int'(row), int'(col));
    assign rd_addr_a = dmm_pkg::addr_a(int'(cmd.idx_row), int'(cmd.idx_inner));
    assign rd_addr_b = dmm_pkg::addr_b(int'(cmd.idx_inner), int'(cmd.idx_col));

    always_ff @(posedge clk)
    begin
        if (wr_a_ok)
            store_a_reg[wr_addr_a] <= value;
        if (cmd.rd_en)
            rd_a_reg <= store_a_reg[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b_ok)
            store_b_reg[wr_addr_b] <= value;
        if (cmd.rd_en)
            rd_b_reg <= store_b_reg[rd_addr_b];
    end

    // pipeline valid tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.rd_en;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
            prod_reg <= rd_a_reg * rd_b_reg;
        if (cmd.acc_clear)
            acc_reg <= '0;
        else if (prod_valid_reg)
            acc_reg <= acc_reg + dmm_pkg::SUM_W'(prod_reg);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row_reg     <= cmd.idx_row;
            out_col_reg     <= cmd.idx_col;
            product_sum_reg <= acc_reg;
            last_reg        <= cmd.emit_last;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign product_sum = product_sum_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire
